[hw/rtl/lru_replacement_tracker_defines.svh]
// ----------------------------------------------------------------------------
// LRU replacement tracker - assertion macros
// Shared helpers for concurrent checks, clocked on clk_i, off during reset.
// ----------------------------------------------------------------------------
`ifndef LRU_REPLACEMENT_TRACKER_DEFINES_SVH
`define LRU_REPLACEMENT_TRACKER_DEFINES_SVH

// Property must hold at every clock edge outside reset.
`define LRT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition must never be seen at a clock edge outside reset.
`define LRT_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

[hw/rtl/lrt_pkg.sv]
// ----------------------------------------------------------------------------
// LRU replacement tracker - package
// Widths, defaults, result kinds and the per-cell control bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package lrt_pkg;

  localparam int unsigned LRT_MAX_ENTRIES = 16;
  localparam int unsigned KEY_W           = 64;
  localparam int unsigned CAP_W           = 5;
  localparam logic [CAP_W-1:0] CAP_RESET  = 5'd16;

  typedef enum logic {
    EV_INSERT = 1'b0,
    EV_EVICT  = 1'b1
  } ev_kind_e;

  // control handed from the top to every cell of the recency chain
  typedef struct packed {
    logic upd;       // request is being applied this cycle
    logic hit;       // some resident cell matched
    logic occupied;  // this position holds a resident key
    logic last;      // this position is the least recent resident
  } lrt_cell_ctrl_t;

endpackage

`default_nettype wire

[hw/rtl/lrt_cell.sv]
// ----------------------------------------------------------------------------
// LRU replacement tracker - recency cell
// One position of the recency-ordered key chain: compare, shift, victim tap.
// ----------------------------------------------------------------------------
`default_nettype none

module lrt_cell
  import lrt_pkg::*;
(
  input  wire logic           clk_i,
  input  wire lrt_cell_ctrl_t ctrl_i,
  input  wire logic [KEY_W-1:0] cmp_key_i,   // key under lookup
  input  wire logic [KEY_W-1:0] key_i,       // from the more recent neighbour
  input  wire logic           hit_above_i,   // match in a less recent cell
  input  wire logic [KEY_W-1:0] vic_i,       // victim OR-chain in
  output logic [KEY_W-1:0]    key_o,
  output logic                match_o,
  output logic                hit_here_o,    // match here or less recent
  output logic [KEY_W-1:0]    vic_o
);

  logic [KEY_W-1:0] key_q;
  logic             shift;

  assign key_o      = key_q;
  assign match_o    = ctrl_i.occupied && (key_q == cmp_key_i);
  assign hit_here_o = match_o || hit_above_i;
  assign vic_o      = vic_i | (ctrl_i.last ? key_q : '0);

  // a miss ages every cell; a hit ages only cells up to the matching one
  assign shift = ctrl_i.upd && (!ctrl_i.hit || hit_here_o);

  always_ff @(posedge clk_i) begin
    if (shift) begin
      key_q <= key_i;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/lru_replacement_tracker.sv]
// ----------------------------------------------------------------------------
// LRU replacement tracker - top level
// Fully associative least-recently-used key store built as a shift chain.
// ----------------------------------------------------------------------------
// Keys are kept in a row of MaxEntries cells ordered by recency, most recent
// in cell 0. Each request carries one 64-bit key; all resident cells compare
// against it at once. A hit moves the key to cell 0 and gives one insert
// result. A miss shifts the whole chain by one and writes the key into cell 0;
// while fewer keys than the capacity register allows are resident the count
// grows, otherwise the key that falls off the least recent end is reported
// first as an evict result, followed by the insert result. Capacity 0 acts
// as 1 and values above MaxEntries saturate. A request waits in the input
// register until the result register is free and no insert is owed; its
// first result is registered. Hits and inserts sustain one request per
// cycle while results are taken; a miss with eviction fills the single
// result register with the evict, then the insert result, holding off the
// next request. The compare-and-shift across the cell row sets cycle time.
// ----------------------------------------------------------------------------
`default_nettype none

`include "lru_replacement_tracker_defines.svh"

module lru_replacement_tracker
  import lrt_pkg::*;
#(
  parameter int unsigned MaxEntries = LRT_MAX_ENTRIES  // 1 .. 256
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  // capacity register
  input  wire logic             cfg_we_i,
  input  wire logic [CAP_W-1:0] cfg_wdata_i,
  // request stream
  input  wire logic             s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  input  wire logic [KEY_W-1:0] s_axis_tdata_i,  // [63:0] access_key
  // result stream
  output logic                  m_axis_tvalid_o,
  input  wire logic             m_axis_tready_i,
  output logic [KEY_W-1:0]      m_axis_tdata_o,  // [63:0] event_key
  output logic                  m_axis_tuser_o,  // [0] event_kind
  output logic                  m_axis_tlast_o   // last_of_run
);

  localparam int unsigned CW    = $clog2(MaxEntries + 1);
  localparam int unsigned CMP_W = (CW > CAP_W) ? CW : CAP_W;

  // registers
  logic [CAP_W-1:0] cap_q;
  logic [CW-1:0]    cnt_q;
  logic             busy_q;       // request waiting in k_q
  logic [KEY_W-1:0] k_q;
  logic             out_valid_q;
  ev_kind_e         out_kind_q;
  logic [KEY_W-1:0] out_key_q;
  logic             out_last_q;
  logic             pend_q;       // insert owed after an eviction
  logic [KEY_W-1:0] pend_key_q;

  // control
  logic             in_fire;
  logic             ofree;
  logic             go;
  logic             hit;
  logic             full;
  logic             evict;
  logic [CMP_W-1:0] cap_ext;
  logic [CMP_W-1:0] eff_cap;

  // cell chain
  logic [KEY_W-1:0]      key_chain [MaxEntries+1];
  logic [KEY_W-1:0]      vic_chain [MaxEntries+1];
  logic [MaxEntries:0]   hit_chain;
  logic [MaxEntries-1:0] match_vec;

  assign in_fire = s_axis_tvalid_i && s_axis_tready_o;

  // effective capacity: zero reads as one, saturate at the cell count
  always_comb begin
    cap_ext = CMP_W'(cap_q);
    if (cap_ext == '0) begin
      eff_cap = CMP_W'(1);
    end else if (cap_ext > CMP_W'(MaxEntries)) begin
      eff_cap = CMP_W'(MaxEntries);
    end else begin
      eff_cap = cap_ext;
    end
  end

  assign hit   = hit_chain[0];
  assign full  = CMP_W'(cnt_q) >= eff_cap;
  assign evict = !hit && full;

  // result register free this cycle
  assign ofree = !out_valid_q || m_axis_tready_i;
  // apply the held request: needs a free result slot and no owed insert
  assign go    = busy_q && !pend_q && ofree;

  assign s_axis_tready_o = !busy_q || go;

  assign key_chain[0]           = k_q;
  assign hit_chain[MaxEntries]  = 1'b0;
  assign vic_chain[MaxEntries]  = '0;

  for (genvar i = 0; i < MaxEntries; i++) begin : g_cell
    lrt_cell_ctrl_t ctrl;

    assign ctrl.upd      = go;
    assign ctrl.hit      = hit;
    assign ctrl.occupied = CW'(i) < cnt_q;
    assign ctrl.last     = cnt_q == CW'(i + 1);

    lrt_cell u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (ctrl),
      .cmp_key_i   (k_q),
      .key_i       (key_chain[i]),
      .hit_above_i (hit_chain[i+1]),
      .vic_i       (vic_chain[i+1]),
      .key_o       (key_chain[i+1]),
      .match_o     (match_vec[i]),
      .hit_here_o  (hit_chain[i]),
      .vic_o       (vic_chain[i])
    );
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q       <= CAP_RESET;
      cnt_q       <= '0;
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
      pend_q      <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end

      if (in_fire) begin
        busy_q <= 1'b1;
      end else if (go) begin
        busy_q <= 1'b0;
      end

      if (go && !hit && !full) begin
        cnt_q <= cnt_q + CW'(1);
      end

      if (pend_q && ofree) begin
        out_valid_q <= 1'b1;
        pend_q      <= 1'b0;
      end else if (go) begin
        out_valid_q <= 1'b1;
        pend_q      <= evict;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      k_q <= s_axis_tdata_i;
    end

    if (pend_q && ofree) begin
      out_kind_q <= EV_INSERT;
      out_key_q  <= pend_key_q;
      out_last_q <= 1'b1;
    end else if (go) begin
      if (evict) begin
        out_kind_q <= EV_EVICT;
        out_key_q  <= vic_chain[0];
        out_last_q <= 1'b0;
        pend_key_q <= k_q;
      end else begin
        out_kind_q <= EV_INSERT;
        out_key_q  <= k_q;
        out_last_q <= 1'b1;
      end
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_key_q;
  assign m_axis_tuser_o  = out_kind_q;
  assign m_axis_tlast_o  = out_last_q;

  // resident keys are unique
  `LRT_ASSERT(a_match_unique, $onehot0(match_vec), "two cells hold the same key")
  `LRT_ASSERT_NEVER(a_cnt_range, cnt_q > CW'(MaxEntries), "resident count beyond cell row")
  `LRT_ASSERT(a_pend_held, pend_q |-> out_valid_q, "owed insert without eviction shown")
  `LRT_ASSERT(a_evict_first,
              (go && evict) |=> (out_valid_q && out_kind_q == EV_EVICT && !out_last_q),
              "eviction not presented first")
  `LRT_ASSERT(a_hit_keeps_cnt, (go && hit) |=> $stable(cnt_q), "hit changed resident count")

endmodule

`default_nettype wire
